>>> hdl/wtcs_pkg.sv
package wtcs_pkg;

	// Fixed-point and raster sizing.
	localparam int FRAC_BITS       = 16;
	localparam int MAX_SCREEN_ROWS = 2048;

	// Field widths.
	localparam int COL_W    = 12;
	localparam int WALLX_W  = 16;
	localparam int LH_W     = 16;
	localparam int DS_W     = 11;
	localparam int DE_W     = 12;
	localparam int TW_W     = 11;
	localparam int THL_W    = 4;
	localparam int SH_W     = 12;
	localparam int TEXC_W   = 10;
	localparam int TEXR_W   = 10;
	localparam int TID_W    = 2;
	localparam int OUTROW_W = 11;
	localparam int IN_W     = 72;
	localparam int OUT_W    = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 12;

	// Largest texture dimension and its log2.
	localparam int TEX_MAX      = 1024;
	localparam int TEX_LOG2_MAX = 10;

	// Row counters hold the clamped end row and any draw start.
	localparam int ROW_BITS = $clog2(MAX_SCREEN_ROWS + 1);
	localparam int ROW_W    = (ROW_BITS > DE_W) ? ROW_BITS : DE_W;

	// Step and position arithmetic.
	localparam int STEP_W = 32;
	localparam int POS_W  = 48;
	localparam int DIV_W  = TEX_LOG2_MAX + FRAC_BITS + 1;
	localparam int CNT_W  = $clog2(DIV_W);
	localparam int OFF_W  = LH_W + 2;

	// Input item kinds.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_PIXEL = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TEX_WIDTH       = 2'd0,
		CFG_TEX_HEIGHT_LOG2 = 2'd1,
		CFG_SCREEN_HEIGHT   = 2'd2
	} cfg_idx_t;

	// Texture identifiers.
	typedef enum logic [TID_W-1:0] {
		TEX_NORTH = 2'd0,
		TEX_SOUTH = 2'd1,
		TEX_WEST  = 2'd2,
		TEX_EAST  = 2'd3
	} tex_id_t;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_MUL
	} state_t;

	// Commands from controller to datapath.
	typedef struct packed {
		logic load;
		logic pix;
		logic div_step;
		logic finish;
	} cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic out_valid;
		logic div_last;
	} status_t;

endpackage

>>> hdl/wall_texture_column_stepper_top.sv
// Channel  Direction  Width  Transfer when
// s_axis   in         72+1   s_tvalid && s_tready (tuser: func)
// m_axis   out        48+1   m_tvalid && m_tready (tlast: last pixel)
// cfg      in         2+12   cfg_valid && cfg_ready (always ready)
//
// Pixel steps follow each other in every cycle
// while the result register drains.
// A column load captures its fields, runs the restoring divider for each
// quotient bit in turn, then does the start-position multiply. The input is
// not ready during the divide and the multiply.
// Reset leaves the span empty, so pixel steps before the first load give nothing.
// A result waiting on m_tready holds the input off, for a column load as well as a pixel.
module wall_texture_column_stepper_top import wtcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// column, wall_x, side, dir_x_positive, dir_y_negative, step_x_positive,
	// step_y_positive, line_height, draw_start, draw_end
	input  logic [IN_W-1:0]      s_tdata,
	// func
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// out_column, out_row, tex_col, tex_row, texture_id, three zero bits
	output logic [OUT_W-1:0]     m_tdata,
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	cmd_t    cmd;
	status_t status;
	logic    ctrl_idle;

	assign cfg_ready = 1'b1;

	// Sequencer.
	wtcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_func   (s_tuser),
		.out_ready (m_tready),
		.status    (status),
		.in_ready  (s_tready),
		.idle      (ctrl_idle),
		.cmd       (cmd)
	);

	// Datapath with divider, multiplier and output register.
	wtcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (s_tdata),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_data  (m_tdata),
		.out_last  (m_tlast)
	);

`ifndef SYNTHESIS
	// Input is only taken while the sequencer is idle.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> ctrl_idle)
		else $error("input ready outside idle state");

	// A column load closes the input on the next cycle.
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == FUNC_LOAD) |=> !s_tready)
		else $error("input ready right after a column load");

	// A result only appears after a pixel step transfer.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tuser == FUNC_PIXEL))
		else $error("result without a pixel step");
`endif

endmodule

>>> hdl/wtcs_ctrl.sv
module wtcs_ctrl import wtcs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_func,
	input  logic    out_ready,
	input  status_t status,
	output logic    in_ready,
	output logic    idle,
	output cmd_t    cmd
);

	state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !status.out_valid || out_ready;
				if (in_valid && in_ready) begin
					if (in_func == FUNC_LOAD) begin
						cmd.load = 1'b1;
						state_d  = ST_DIV;
					end else begin
						cmd.pix = 1'b1;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign idle = (state_q == ST_IDLE);

endmodule

>>> hdl/wtcs_dp.sv
module wtcs_dp import wtcs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output status_t              status,
	input  logic [IN_W-1:0]      in_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_wdata,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [OUT_W-1:0]     out_data,
	output logic                 out_last
);

	// Unpacked input fields.
	logic [COL_W-1:0]   f_column;
	logic [WALLX_W-1:0] f_wall_x;
	logic               f_side, f_dxp, f_dyn, f_sxp, f_syp;
	logic [LH_W-1:0]    f_lh;
	logic [DS_W-1:0]    f_ds;
	logic [DE_W-1:0]    f_de;

	assign f_column = in_data[11:0];
	assign f_wall_x = in_data[27:12];
	assign f_side   = in_data[28];
	assign f_dxp    = in_data[29];
	assign f_dyn    = in_data[30];
	assign f_sxp    = in_data[31];
	assign f_syp    = in_data[32];
	assign f_lh     = in_data[48:33];
	assign f_ds     = in_data[59:49];
	assign f_de     = in_data[71:60];

	// Configuration registers.
	logic [TW_W-1:0]  tex_width_q;
	logic [THL_W-1:0] tex_hlog2_q;
	logic [SH_W-1:0]  screen_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_width_q     <= TW_W'(64);
			tex_hlog2_q     <= THL_W'(6);
			screen_height_q <= SH_W'(480);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_TEX_WIDTH:       tex_width_q     <= cfg_wdata[TW_W-1:0];
				CFG_TEX_HEIGHT_LOG2: tex_hlog2_q     <= cfg_wdata[THL_W-1:0];
				CFG_SCREEN_HEIGHT:   screen_height_q <= cfg_wdata[SH_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective width and height after clamping.
	logic [TW_W-1:0]   eff_w;
	logic [THL_W-1:0]  eff_hl;
	logic [TEXR_W-1:0] h_mask;
	logic [DIV_W-1:0]  dividend;

	assign eff_w = (tex_width_q == '0) ? TW_W'(1) :
		(tex_width_q > TW_W'(TEX_MAX)) ? TW_W'(TEX_MAX) : tex_width_q;
	assign eff_hl = (tex_hlog2_q > THL_W'(TEX_LOG2_MAX)) ? THL_W'(TEX_LOG2_MAX) : tex_hlog2_q;
	assign h_mask = TEXR_W'((DIV_W'(1) << eff_hl) - DIV_W'(1));
	assign dividend = DIV_W'(1) << (DIV_W'(eff_hl) + DIV_W'(FRAC_BITS));

	// Column state registers.
	logic [COL_W-1:0]       cur_column_q;
	logic [ROW_W-1:0]       cur_row_q;
	logic [ROW_W-1:0]       end_row_q;
	logic [TID_W-1:0]       held_texture_q;
	logic [TEXC_W-1:0]      held_tex_col_q;
	logic [STEP_W-1:0]      tex_step_q;
	logic [POS_W-1:0]       tex_pos_q;
	logic [LH_W-1:0]        lh_q;
	logic [OFF_W-1:0]       off_q;
	logic [TW_W+WALLX_W-1:0] col_prod_q;
	logic                   mirror_q;

	// Divider registers.
	logic [DIV_W-1:0] quot_q;
	logic [LH_W-1:0]  rem_q;
	logic [CNT_W-1:0] cnt_q;

	// Load-time values.
	logic [LH_W-1:0]      lh_eff;
	logic [DE_W-1:0]      de_clamp;
	logic [OFF_W-1:0]     off_d;
	logic [ROW_W+DE_W-1:0] de_ext;

	assign lh_eff = (f_lh == '0) ? LH_W'(1) : f_lh;
	assign de_ext = (ROW_W+DE_W)'(f_de);
	assign de_clamp = (de_ext > (ROW_W+DE_W)'(MAX_SCREEN_ROWS)) ?
		DE_W'(MAX_SCREEN_ROWS) : f_de;
	assign off_d = OFF_W'(f_ds) - OFF_W'(screen_height_q >> 1) + OFF_W'(f_lh >> 1);

	// One restoring division step.
	logic [LH_W:0]   trial;
	logic            q_bit;
	logic [LH_W:0]   trial_sub;

	assign trial     = {rem_q, quot_q[DIV_W-1]};
	assign q_bit     = (trial >= {1'b0, lh_q});
	assign trial_sub = trial - {1'b0, lh_q};

	// Quotient saturated to the step width.
	logic [DIV_W+STEP_W-1:0] q_ext;
	logic [STEP_W-1:0]       step_sat;

	assign q_ext    = (DIV_W+STEP_W)'(quot_q);
	assign step_sat = (|(q_ext >> STEP_W)) ? '1 : q_ext[STEP_W-1:0];

	// Start position and mirrored texture column.
	logic signed [OFF_W+STEP_W:0] pos_prod;
	logic [TW_W-1:0]              col_raw;
	logic [TW_W-1:0]              col_mir;

	assign pos_prod = $signed(off_q) * $signed({1'b0, step_sat});
	assign col_raw  = col_prod_q[TW_W+WALLX_W-1:WALLX_W];
	assign col_mir  = eff_w - TW_W'(1) - col_raw;

	assign status.div_last = (cnt_q == CNT_W'(DIV_W - 1));

	// Span bookkeeping; reset leaves the span empty.
	logic span_live;
	assign span_live = (cur_row_q < end_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			end_row_q <= '0;
		end else if (cmd.load) begin
			cur_row_q <= ROW_W'(f_ds);
			end_row_q <= ROW_W'(de_clamp);
		end else if (cmd.pix && span_live) begin
			cur_row_q <= cur_row_q + ROW_W'(1);
		end
	end

	// Load capture, division and position set-up.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_column_q   <= f_column;
			held_texture_q <= (f_side == 1'b0) ? (f_sxp ? TEX_SOUTH : TEX_NORTH) :
				(f_syp ? TEX_EAST : TEX_WEST);
			col_prod_q     <= (TW_W+WALLX_W)'(f_wall_x) * (TW_W+WALLX_W)'(eff_w);
			mirror_q       <= (f_side && f_dyn) || (!f_side && f_dxp);
			lh_q           <= lh_eff;
			off_q          <= off_d;
			quot_q         <= dividend;
			rem_q          <= '0;
			cnt_q          <= '0;
		end else if (cmd.div_step) begin
			quot_q <= {quot_q[DIV_W-2:0], q_bit};
			rem_q  <= q_bit ? trial_sub[LH_W-1:0] : trial[LH_W-1:0];
			cnt_q  <= cnt_q + CNT_W'(1);
		end
		if (cmd.finish) begin
			tex_step_q     <= step_sat;
			tex_pos_q      <= pos_prod[POS_W-1:0];
			held_tex_col_q <= mirror_q ? col_mir[TEXC_W-1:0] : col_raw[TEXC_W-1:0];
		end else if (cmd.pix && span_live) begin
			tex_pos_q <= tex_pos_q + POS_W'(tex_step_q);
		end
	end

	// Output register.
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.pix && span_live) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pix && span_live) begin
			out_data <= {3'b000, held_texture_q,
				tex_pos_q[FRAC_BITS +: TEXR_W] & h_mask,
				held_tex_col_q, cur_row_q[OUTROW_W-1:0], cur_column_q};
			out_last <= (cur_row_q + ROW_W'(1) == end_row_q);
		end
	end

	assign out_valid        = out_valid_q;
	assign status.out_valid = out_valid_q;

endmodule
